/* rtl/id3tfe_pkg.sv */
// ----------------------------------------------------------------------------
// id3tfe_pkg
// Types, constants and helper functions shared by the ID3v2 text frame
// extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package id3tfe_pkg;

  // Width of the tag size counter; a larger syncsafe tag size saturates.
  localparam int TAG_SIZE_BITS = 28;
  localparam int BYTES_LEFT_W  = 28;
  localparam logic [BYTES_LEFT_W-1:0] TAG_SIZE_CAP =
    BYTES_LEFT_W'((64'd1 << TAG_SIZE_BITS) - 64'd1);

  // Depth of the queues on both sides of the parser.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Tag and frame header geometry.
  localparam logic [3:0] TAG_HDR_LAST   = 4'd9;
  localparam logic [3:0] FRM_HDR_LEN_V3 = 4'd10;
  localparam logic [3:0] FRM_HDR_LEN_V2 = 4'd6;
  localparam logic [BYTES_LEFT_W-1:0] MIN_BYTES_LEFT = BYTES_LEFT_W'(10);
  localparam logic [7:0] VERSION_WIDE = 8'd3;
  localparam logic [7:0] VERSION_SYNC = 8'd4;
  localparam logic [6:0] SYNCSAFE_MASK = 7'h7F;

  // Frame identifiers.
  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;
  localparam logic [31:0] ID_TT2  = 32'h0054_5432;
  localparam logic [31:0] ID_TP1  = 32'h0054_5031;
  localparam logic [31:0] ID_TAL  = 32'h0054_414C;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FRAME_HDR,
    PH_ENCODING,
    PH_PAYLOAD,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_TITLE  = 2'd1,
    KIND_ARTIST = 2'd2,
    KIND_ALBUM  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_END_REACHED = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_PADDING     = 2'd2,
    ST_BAD_SIZE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       tag_start;
  } in_word_t;

  typedef struct packed {
    logic [1:0] field_kind;
    logic [7:0] text_byte;
    logic [7:0] text_encoding;
    logic       frame_first;
    logic       frame_last;
    logic       tag_done;
    logic [1:0] end_status;
    logic       found_any;
  } out_word_t;

  // Expected tag magic byte at header positions zero to two ("ID3").
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd0:    m = 8'h49;
      4'd1:    m = 8'h44;
      default: m = 8'h33;
    endcase
    return m;
  endfunction

  // Maps a frame identifier to the text field it carries.
  function automatic kind_t lookup_kind(input logic [7:0] ver, input logic [31:0] ident);
    kind_t k;
    k = KIND_NONE;
    if (ver >= VERSION_WIDE) begin
      if (ident == ID_TIT2) k = KIND_TITLE;
      else if (ident == ID_TPE1) k = KIND_ARTIST;
      else if (ident == ID_TALB) k = KIND_ALBUM;
    end else begin
      if (ident == ID_TT2) k = KIND_TITLE;
      else if (ident == ID_TP1) k = KIND_ARTIST;
      else if (ident == ID_TAL) k = KIND_ALBUM;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/id3v2_text_frame_extractor_core.sv */
// ----------------------------------------------------------------------------
// id3v2_text_frame_extractor_core
// Walks an ID3v2 tag byte by byte and hands out the text bytes of the title,
// artist and album frames, followed by a done word with the end status.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload                  Word
//   input     push / full        in_item  (in_word_t)     one tag byte
//   result    pop / empty        out_item (out_word_t)    text byte or done
//
// The parser takes one byte from the input queue per clock cycle while the
// result queue has room, so a steady stream runs at one byte per cycle when
// results are popped as fast. An accepted byte is stored in the input queue;
// the parser forms its result from the queue head and writes it into the
// result queue, from where the word can be popped.
// Reset is synchronous on rst_n and leaves both queues empty and the parser
// idle; the first byte with tag_start set begins a tag.
// The parser stalls only while the result queue is full, and push is refused
// only while the four-word input queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module id3v2_text_frame_extractor_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire id3tfe_pkg::in_word_t  in_item,
  output logic                       full,
  output logic                       empty,
  input  wire logic                  pop,
  output id3tfe_pkg::out_word_t      out_item
);
  import id3tfe_pkg::*;

  // The front end: an input queue that takes bytes whenever it has room.
  logic     head_valid;
  in_word_t head_word;
  logic     parse_fire;

  // The back end: the parser and the result queue it writes.
  logic      res_valid;
  out_word_t res_word;
  logic      outq_full;

  // A byte moves into the parser when there is room for whatever result it
  // may cause; a byte that causes no result still needs that room reserved.
  assign parse_fire = head_valid && !outq_full;

  id3tfe_inq u_inq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_word    (in_item),
    .full       (full),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (parse_fire)
  );

  id3tfe_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (parse_fire),
    .cur_word  (head_word),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  id3tfe_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .wr_word   (res_word),
    .full      (outq_full),
    .empty     (empty),
    .head_word (out_item),
    .pop       (pop)
  );

  // A word with no text kind is only ever a done word.
  a_kindless_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.field_kind == KIND_NONE) |-> out_item.tag_done)
    else $error("result word carries neither text nor done");

  // Status and found flag are only meaningful on a done word.
  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.tag_done) |->
      (out_item.end_status == ST_END_REACHED && !out_item.found_any))
    else $error("end status or found flag set without done");

  // Frame boundary markers belong to text bytes.
  a_marks_need_text: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.frame_first || out_item.frame_last)) |->
      out_item.field_kind != KIND_NONE)
    else $error("frame marker on a word without text");

  // The parser never writes a result into a full result queue.
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !outq_full)
    else $error("result produced while the result queue is full");

endmodule

`default_nettype wire

/* rtl/id3tfe_inq.sv */
// ----------------------------------------------------------------------------
// id3tfe_inq
// Short input queue that takes tag bytes and hands them to the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfe_inq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire id3tfe_pkg::in_word_t wr_word,
  output logic                      full,
  output logic                      head_valid,
  output id3tfe_pkg::in_word_t      head_word,
  input  wire logic                 pop
);
  import id3tfe_pkg::*;

  in_word_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_word  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_word;
  end

endmodule

`default_nettype wire

/* rtl/id3tfe_parser.sv */
// ----------------------------------------------------------------------------
// id3tfe_parser
// Tag and frame header walker: updates the parse state by one byte per cycle
// while fire is high and forms at most one result word for that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfe_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire id3tfe_pkg::in_word_t  cur_word,
  output logic                       res_valid,
  output id3tfe_pkg::out_word_t      res_word
);
  import id3tfe_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [3:0]              hdr_idx_r, hdr_idx_nxt;
  logic [BYTES_LEFT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]              major_r, major_nxt;
  logic [31:0]             ident_r, ident_nxt;
  logic [31:0]             frame_len_r, frame_len_nxt;
  logic [31:0]             payload_left_r, payload_left_nxt;
  kind_t                   cur_kind_r, cur_kind_nxt;
  logic [7:0]              cur_enc_r, cur_enc_nxt;
  logic                    seen_text_r, seen_text_nxt;

  // Start-of-tag view of the state.
  phase_t                  ph_e;
  logic [3:0]              idx_e;
  logic [BYTES_LEFT_W-1:0] bl_e;
  logic [7:0]              major_e;
  logic [31:0]             ident_e;
  logic [31:0]             len_e;
  logic [31:0]             pl_e;
  kind_t                   kind_e;
  logic [7:0]              enc_e;
  logic                    seen_e;

  logic [BYTES_LEFT_W-1:0] bl_dec;
  logic [31:0]             pl_dec;
  logic [4:0]              idx_inc;
  logic [3:0]              hdr_len;
  logic [7:0]              first_id;
  logic [BYTES_LEFT_W-1:0] size_acc;
  kind_t                   found_kind;
  logic [7:0]              b;

  logic    done;
  status_t status;
  logic    frame_end;
  logic    emit;
  logic    first_flag;
  logic    last_flag;

  assign b = cur_word.byte_value;

  // Next state of the parser.
  always_comb begin
    if (cur_word.tag_start) begin
      ph_e    = PH_HEADER;
      idx_e   = '0;
      bl_e    = '0;
      major_e = '0;
      ident_e = '0;
      len_e   = '0;
      pl_e    = '0;
      kind_e  = KIND_NONE;
      enc_e   = '0;
      seen_e  = 1'b0;
    end else begin
      ph_e    = phase_r;
      idx_e   = hdr_idx_r;
      bl_e    = bytes_left_r;
      major_e = major_r;
      ident_e = ident_r;
      len_e   = frame_len_r;
      pl_e    = payload_left_r;
      kind_e  = cur_kind_r;
      enc_e   = cur_enc_r;
      seen_e  = seen_text_r;
    end

    phase_nxt        = ph_e;
    hdr_idx_nxt      = idx_e;
    bytes_left_nxt   = bl_e;
    major_nxt        = major_e;
    ident_nxt        = ident_e;
    frame_len_nxt    = len_e;
    payload_left_nxt = pl_e;
    cur_kind_nxt     = kind_e;
    cur_enc_nxt      = enc_e;
    seen_text_nxt    = seen_e;

    done       = 1'b0;
    status     = ST_END_REACHED;
    frame_end  = 1'b0;
    emit       = 1'b0;
    first_flag = 1'b0;
    last_flag  = 1'b0;

    bl_dec     = (bl_e != '0) ? bl_e - 1'b1 : bl_e;
    pl_dec     = (pl_e != '0) ? pl_e - 1'b1 : pl_e;
    idx_inc    = {1'b0, idx_e} + 5'd1;
    hdr_len    = (major_e >= VERSION_WIDE) ? FRM_HDR_LEN_V3 : FRM_HDR_LEN_V2;
    size_acc   = bl_e;
    first_id   = '0;
    found_kind = KIND_NONE;

    case (ph_e)
      PH_HEADER: begin
        if (idx_e < 4'd3) begin
          if (b != magic_byte(idx_e)) begin
            done   = 1'b1;
            status = ST_BAD_MAGIC;
          end
        end else if (idx_e == 4'd3) begin
          major_nxt = b;
        end else if (idx_e >= 4'd6) begin
          size_acc = {bl_e[BYTES_LEFT_W-8:0], b[6:0] & SYNCSAFE_MASK};
        end
        bytes_left_nxt = size_acc;
        if (!done) begin
          if (idx_e >= TAG_HDR_LAST) begin
            if (size_acc > TAG_SIZE_CAP) bytes_left_nxt = TAG_SIZE_CAP;
            if (bytes_left_nxt <= MIN_BYTES_LEFT) begin
              done = 1'b1;
            end else begin
              phase_nxt     = PH_FRAME_HDR;
              hdr_idx_nxt   = '0;
              ident_nxt     = '0;
              frame_len_nxt = '0;
            end
          end else begin
            hdr_idx_nxt = idx_inc[3:0];
          end
        end
      end
      PH_FRAME_HDR: begin
        bytes_left_nxt = bl_dec;
        if (major_e >= VERSION_WIDE) begin
          if (idx_e < 4'd4) begin
            ident_nxt = {ident_e[23:0], b};
          end else if (idx_e < 4'd8) begin
            if (major_e == VERSION_SYNC) begin
              frame_len_nxt = {4'b0, len_e[20:0], b[6:0] & SYNCSAFE_MASK};
            end else begin
              frame_len_nxt = {len_e[23:0], b};
            end
          end
          first_id = ident_nxt[31:24];
        end else begin
          if (idx_e < 4'd3) begin
            ident_nxt = {8'b0, ident_e[15:0], b};
          end else if (idx_e < 4'd6) begin
            frame_len_nxt = {8'b0, len_e[15:0], b};
          end
          first_id = ident_nxt[23:16];
        end
        hdr_idx_nxt = idx_inc[3:0];
        if (idx_inc >= {1'b0, hdr_len}) begin
          if (first_id == 8'h00) begin
            done   = 1'b1;
            status = ST_PADDING;
          end else if (frame_len_nxt == '0 ||
                       frame_len_nxt > {{(32-BYTES_LEFT_W){1'b0}}, bl_dec}) begin
            done   = 1'b1;
            status = ST_BAD_SIZE;
          end else begin
            found_kind       = lookup_kind(major_e, ident_nxt);
            cur_kind_nxt     = found_kind;
            payload_left_nxt = frame_len_nxt;
            phase_nxt        = (found_kind != KIND_NONE) ? PH_ENCODING : PH_SKIP;
            hdr_idx_nxt      = '0;
          end
        end
      end
      PH_ENCODING: begin
        bytes_left_nxt   = bl_dec;
        cur_enc_nxt      = b;
        payload_left_nxt = pl_dec;
        phase_nxt        = PH_PAYLOAD;
        frame_end        = (pl_dec == '0);
      end
      PH_PAYLOAD: begin
        bytes_left_nxt   = bl_dec;
        first_flag       = (len_e != '0) && (pl_e == len_e - 32'd1);
        payload_left_nxt = pl_dec;
        emit             = (kind_e != KIND_NONE);
        last_flag        = (pl_dec == '0);
        seen_text_nxt    = 1'b1;
        frame_end        = (pl_dec == '0);
      end
      PH_SKIP: begin
        bytes_left_nxt   = bl_dec;
        payload_left_nxt = pl_dec;
        frame_end        = (pl_dec == '0);
      end
      default: begin
      end
    endcase

    if (frame_end) begin
      cur_kind_nxt = KIND_NONE;
      if (bl_dec <= MIN_BYTES_LEFT) begin
        done   = 1'b1;
        status = ST_END_REACHED;
      end else begin
        phase_nxt     = PH_FRAME_HDR;
        hdr_idx_nxt   = '0;
        ident_nxt     = '0;
        frame_len_nxt = '0;
      end
    end

    if (done) phase_nxt = PH_DONE;
  end

  // Result word for the byte in hand.
  always_comb begin
    res_valid              = fire && (emit || done);
    res_word.field_kind    = emit ? kind_e : KIND_NONE;
    res_word.text_byte     = emit ? b : 8'h00;
    res_word.text_encoding = emit ? enc_e : 8'h00;
    res_word.frame_first   = first_flag;
    res_word.frame_last    = last_flag;
    res_word.tag_done      = done;
    res_word.end_status    = done ? status : ST_END_REACHED;
    res_word.found_any     = done && seen_text_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      hdr_idx_r      <= '0;
      bytes_left_r   <= '0;
      major_r        <= '0;
      ident_r        <= '0;
      frame_len_r    <= '0;
      payload_left_r <= '0;
      cur_kind_r     <= KIND_NONE;
      cur_enc_r      <= '0;
      seen_text_r    <= 1'b0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      bytes_left_r   <= bytes_left_nxt;
      major_r        <= major_nxt;
      ident_r        <= ident_nxt;
      frame_len_r    <= frame_len_nxt;
      payload_left_r <= payload_left_nxt;
      cur_kind_r     <= cur_kind_nxt;
      cur_enc_r      <= cur_enc_nxt;
      seen_text_r    <= seen_text_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/id3tfe_outq.sv */
// ----------------------------------------------------------------------------
// id3tfe_outq
// Short result queue between the parser and the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfe_outq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire id3tfe_pkg::out_word_t wr_word,
  output logic                       full,
  output logic                       empty,
  output id3tfe_pkg::out_word_t      head_word,
  input  wire logic                  pop
);
  import id3tfe_pkg::*;

  out_word_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_word = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_word;
  end

endmodule

`default_nettype wire

/* bench/id3v2_text_frame_extractor_core_tb.sv */
// ----------------------------------------------------------------------------
// id3v2_text_frame_extractor_core_tb
// Self-checking bench for the ID3v2 text frame extractor. A short directed
// run covers the magic checks, a tag too small for frames and bytes outside
// a tag. After it comes a long run of generated tags of every header layout
// with recognized, near-miss and foreign frames, ending cleanly, in padding,
// in a bad frame size, cut short by a restart or broken in the magic. A
// behavioral tracker predicts every result word from the bytes the block
// accepts and compares the popped words against it, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module id3v2_text_frame_extractor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import id3tfe_pkg::*;

  // Frame identifiers the parser must recognize, in both header layouts.
  localparam logic [31:0] V3_TITLE  = "TIT2";
  localparam logic [31:0] V3_ARTIST = "TPE1";
  localparam logic [31:0] V3_ALBUM  = "TALB";
  localparam logic [31:0] V2_TITLE  = "TT2";
  localparam logic [31:0] V2_ARTIST = "TP1";
  localparam logic [31:0] V2_ALBUM  = "TAL";
  localparam logic [23:0] TAG_MAGIC = "ID3";

  // Generated stream length, the long receiver hold-off, the calm tail, the drain wait and the watchdog.
  localparam int RANDOM_BYTES = 1300;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_TAIL    = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 4000;

  typedef enum int {
    TAG_END_CLEAN,
    TAG_END_PADDING,
    TAG_END_BAD_LEN
  } tag_end_t;

  // --------------------------------------------------------------------------
  // Tracker: a cycle-free copy of the parser state. Every accepted byte goes
  // through note_byte, which queues the word the block has to produce for it,
  // if any. check_word compares a popped word with the oldest queued one.
  // --------------------------------------------------------------------------
  class text_frame_tracker;
    phase_t      phase;
    logic [3:0]  hdr_idx;
    logic [27:0] tag_left;
    logic [7:0]  version;
    logic [31:0] ident;
    logic [31:0] frame_len;
    logic [31:0] pay_left;
    kind_t       cur_kind;
    logic [7:0]  cur_enc;
    bit          seen_text;
    out_word_t   expected_q[$];
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase     = PH_IDLE;
      hdr_idx   = '0;
      tag_left  = '0;
      version   = '0;
      ident     = '0;
      frame_len = '0;
      pay_left  = '0;
      cur_kind  = KIND_NONE;
      cur_enc   = '0;
      seen_text = 1'b0;
    endfunction

    function void open_frame();
      phase     = PH_FRAME_HDR;
      hdr_idx   = '0;
      ident     = '0;
      frame_len = '0;
    endfunction

    // Every byte past the tag header uses up one byte of the tag size.
    function void take_byte();
      if (tag_left != 0) tag_left = tag_left - 1'b1;
    endfunction

    function void note_byte(in_word_t w);
      logic [7:0] b;
      logic [3:0] idx;
      logic [3:0] hdr_len;
      logic [7:0] first_id;
      out_word_t  r;
      bit         done;
      bit         frame_end;
      status_t    st;
      b         = w.byte_value;
      r         = '0;
      done      = 1'b0;
      frame_end = 1'b0;
      st        = ST_END_REACHED;
      if (w.tag_start) begin
        clear();
        phase = PH_HEADER;
      end
      if (phase == PH_IDLE || phase == PH_DONE) return;
      case (phase)
        PH_HEADER: begin
          idx = hdr_idx;
          if (idx < 3) begin
            if (b != TAG_MAGIC[8*(2-idx) +: 8]) begin
              done = 1'b1;
              st   = ST_BAD_MAGIC;
            end
          end else if (idx == 3) begin
            version = b;
          end else if (idx >= 6) begin
            tag_left = {tag_left[20:0], b[6:0]};
          end
          if (!done) begin
            if (idx >= 9) begin
              if (tag_left <= 10) done = 1'b1;
              else open_frame();
            end else begin
              hdr_idx = idx + 4'd1;
            end
          end
        end
        PH_FRAME_HDR: begin
          idx     = hdr_idx;
          hdr_len = (version >= 3) ? 4'd10 : 4'd6;
          take_byte();
          if (version >= 3) begin
            if (idx < 4) ident = {ident[23:0], b};
            else if (idx < 8) begin
              if (version == 4) frame_len = {4'd0, frame_len[20:0], b[6:0]};
              else frame_len = {frame_len[23:0], b};
            end
          end else begin
            if (idx < 3) ident = {8'h00, ident[15:0], b};
            else if (idx < 6) frame_len = {8'h00, frame_len[15:0], b};
          end
          idx     = idx + 4'd1;
          hdr_idx = idx;
          if (idx >= hdr_len) begin
            first_id = (version >= 3) ? ident[31:24] : ident[23:16];
            if (first_id == 8'h00) begin
              done = 1'b1;
              st   = ST_PADDING;
            end else if (frame_len == 0 || frame_len > tag_left) begin
              done = 1'b1;
              st   = ST_BAD_SIZE;
            end else begin
              cur_kind = KIND_NONE;
              if (version >= 3) begin
                case (ident)
                  V3_TITLE:  cur_kind = KIND_TITLE;
                  V3_ARTIST: cur_kind = KIND_ARTIST;
                  V3_ALBUM:  cur_kind = KIND_ALBUM;
                  default:   cur_kind = KIND_NONE;
                endcase
              end else begin
                case (ident)
                  V2_TITLE:  cur_kind = KIND_TITLE;
                  V2_ARTIST: cur_kind = KIND_ARTIST;
                  V2_ALBUM:  cur_kind = KIND_ALBUM;
                  default:   cur_kind = KIND_NONE;
                endcase
              end
              pay_left = frame_len;
              phase    = (cur_kind != KIND_NONE) ? PH_ENCODING : PH_SKIP;
              hdr_idx  = '0;
            end
          end
        end
        PH_ENCODING: begin
          take_byte();
          cur_enc = b;
          if (pay_left != 0) pay_left = pay_left - 1;
          phase = PH_PAYLOAD;
          if (pay_left == 0) frame_end = 1'b1;
        end
        PH_PAYLOAD: begin
          take_byte();
          r.frame_first = (frame_len != 0 && pay_left == frame_len - 1);
          if (pay_left != 0) pay_left = pay_left - 1;
          r.field_kind    = cur_kind;
          r.text_byte     = b;
          r.text_encoding = cur_enc;
          r.frame_last    = (pay_left == 0);
          seen_text       = 1'b1;
          if (pay_left == 0) frame_end = 1'b1;
        end
        PH_SKIP: begin
          take_byte();
          if (pay_left != 0) pay_left = pay_left - 1;
          if (pay_left == 0) frame_end = 1'b1;
        end
        default: ;
      endcase
      if (frame_end) begin
        cur_kind = KIND_NONE;
        if (tag_left <= 10) done = 1'b1;
        else open_frame();
      end
      if (done) phase = PH_DONE;
      if (r.field_kind == KIND_NONE && !done) return;
      r.tag_done   = done;
      r.end_status = done ? st : ST_END_REACHED;
      r.found_any  = done ? seen_text : 1'b0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task compare_field(string what, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result word", 32'(got), '0);
        return;
      end
      want = expected_q.pop_front();
      compare_field("field_kind", got.field_kind, want.field_kind);
      compare_field("text_byte", got.text_byte, want.text_byte);
      compare_field("text_encoding", got.text_encoding, want.text_encoding);
      compare_field("frame_first", got.frame_first, want.frame_first);
      compare_field("frame_last", got.frame_last, want.frame_last);
      compare_field("tag_done", got.tag_done, want.tag_done);
      compare_field("end_status", got.end_status, want.end_status);
      compare_field("found_any", got.found_any, want.found_any);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  logic      empty;
  logic      pop;
  in_word_t  in_item;
  out_word_t out_item;

  text_frame_tracker tracker;
  in_word_t          byte_stream[$];
  int                live_bytes;
  int                bytes_sent;
  int                gap_odds;
  bit                calm;
  int                stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  id3v2_text_frame_extractor_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // --------------------------------------------------------------------------
  // Stimulus construction. The whole byte stream is built before reset is
  // released, so the drivers only deal with the handshakes.
  // --------------------------------------------------------------------------
  function automatic void queue_byte(logic [7:0] b, bit start);
    in_word_t w;
    w.byte_value = b;
    w.tag_start  = start;
    byte_stream.insert(byte_stream.size(), w);
  endfunction

  // Picks a frame identifier: mostly one of the three text frames of the
  // layout, sometimes a near miss with one byte changed, sometimes anything.
  // The first byte is never zero, since a zero there means padding.
  function automatic logic [31:0] pick_ident(int ver);
    logic [31:0] id;
    int          nb;
    int          k;
    int          r;
    int          p;
    int          i;
    nb = (ver >= 3) ? 4 : 3;
    k  = $urandom_range(0, 2);
    r  = $urandom_range(0, 9);
    if (ver >= 3) id = (k == 0) ? V3_TITLE : (k == 1) ? V3_ARTIST : V3_ALBUM;
    else id = (k == 0) ? V2_TITLE : (k == 1) ? V2_ARTIST : V2_ALBUM;
    if (r == 9) begin
      for (i = 0; i < nb; i++) id[8*i +: 8] = 8'($urandom_range(0, 255));
    end else if (r >= 7) begin
      p = $urandom_range(0, nb - 1);
      id[8*p +: 8] = 8'($urandom_range(0, 255));
    end
    if (id[8*(nb-1) +: 8] == 8'h00) id[8*(nb-1) +: 8] = 8'h54;
    return id;
  endfunction

  // Appends a frame header in the layout of the given version. Version 4
  // sizes are syncsafe; the ignored top bit of each size byte is sometimes set.
  task automatic put_frame_head(ref logic [7:0] q[$], input int ver,
                                input logic [31:0] id, input logic [31:0] len);
    int i;
    for (i = ((ver >= 3) ? 3 : 2); i >= 0; i--) q.insert(q.size(), id[8*i +: 8]);
    if (ver == 4) begin
      for (i = 3; i >= 0; i--)
        q.insert(q.size(), {($urandom_range(0, 7) == 0), len[7*i +: 7]});
    end else if (ver >= 3) begin
      for (i = 3; i >= 0; i--) q.insert(q.size(), len[8*i +: 8]);
    end else begin
      for (i = 2; i >= 0; i--) q.insert(q.size(), len[8*i +: 8]);
    end
    if (ver >= 3) begin
      q.insert(q.size(), 8'($urandom_range(0, 255)));
      q.insert(q.size(), 8'($urandom_range(0, 255)));
    end
  endtask

  // Builds one tag. The tag size is at times the largest one, else counts the frames
  // plus a tail: a tail of ten or less ends the walk cleanly after the last frame, a
  // longer one is filled by a padding header or a frame header with a bad size.
  task automatic add_tag();
    logic [7:0]  body[$];
    logic [7:0]  tag[$];
    logic [27:0] tsize;
    logic [31:0] len;
    tag_end_t    ending;
    int          ver;
    int          hl;
    int          tail;
    int          cut;
    int          p;
    int          i;
    bit          huge;
    case ($urandom_range(0, 9))
      0, 1, 2: ver = 2;
      3, 4, 5: ver = 3;
      6, 7, 8: ver = 4;
      default: ver = $urandom_range(0, 255);
    endcase
    hl = (ver >= 3) ? 10 : 6;
    repeat ($urandom_range(0, 3)) begin
      len = $urandom_range(1, 10);
      put_frame_head(body, ver, pick_ident(ver), len);
      body.insert(body.size(), ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 3)));
      repeat (len - 1) body.insert(body.size(), 8'($urandom_range(0, 255)));
    end
    huge   = ($urandom_range(0, 19) == 0);
    ending = huge ? tag_end_t'($urandom_range(1, 2)) : tag_end_t'($urandom_range(0, 2));
    tail   = (ending == TAG_END_CLEAN) ? $urandom_range(0, 10) : $urandom_range(11, 40);
    tsize  = huge ? 28'hFFF_FFFF : 28'(body.size() + tail);

    tag = '{8'h49, 8'h44, 8'h33};
    tag.insert(tag.size(), 8'(ver));
    tag.insert(tag.size(), 8'($urandom_range(0, 255)));
    tag.insert(tag.size(), 8'($urandom_range(0, 255)));
    for (i = 3; i >= 0; i--)
      tag.insert(tag.size(), {($urandom_range(0, 7) == 0), tsize[7*i +: 7]});
    foreach (body[j]) tag.insert(tag.size(), body[j]);
    if (ending == TAG_END_PADDING) begin
      tag.insert(tag.size(), 8'h00);
      repeat (hl - 1) tag.insert(tag.size(), 8'($urandom_range(0, 255)));
    end else if (ending == TAG_END_BAD_LEN) begin
      if (huge || $urandom_range(0, 2) == 0) len = 0;
      else if (ver >= 3 && ver != 4 && $urandom_range(0, 3) == 0) len = 32'hFFFF_FFFF;
      else len = (tail - hl) + $urandom_range(1, 300);
      put_frame_head(tag, ver, pick_ident(ver), len);
    end

    // Noise: a broken magic byte, or a tag cut short by the next restart.
    case ($urandom_range(0, 15))
      0: begin
        p = $urandom_range(0, 2);
        tag[p] = tag[p] ^ 8'($urandom_range(1, 255));
        cut = p + 1 + $urandom_range(0, 3);
        while (tag.size() > cut) void'(tag.pop_back());
      end
      1: begin
        cut = $urandom_range(1, tag.size() - 1);
        while (tag.size() > cut) void'(tag.pop_back());
      end
      default: ;
    endcase
    foreach (tag[j]) queue_byte(tag[j], j == 0);
    live_bytes += tag.size();
    // Stray bytes after a tag only matter to a tag that was cut short.
    repeat ($urandom_range(0, 2)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Input side. The next byte is offered at the falling edge and counts as
  // accepted at the rising edge where push is high and full is low. Idle
  // bursts follow accepted words at a rate that changes every 64 bytes; in
  // the last stretch of the stream there are none.
  // --------------------------------------------------------------------------
  task automatic drive_bytes();
    int idx;
    int gap;
    idx = 0;
    gap = 0;
    while (idx < byte_stream.size()) begin
      @(negedge clk);
      if (idx >= byte_stream.size() - CALM_TAIL) calm = 1'b1;
      if (gap > 0 && !calm) begin
        push <= 1'b0;
        gap--;
      end else begin
        push    <= 1'b1;
        in_item <= byte_stream[idx];
      end
      @(posedge clk);
      if (push && !full) begin
        tracker.note_byte(in_item);
        idx++;
        bytes_sent = idx;
        if (idx % 64 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 3;
            default: gap_odds = 12;
          endcase
        end
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 12);
      end
    end
    @(negedge clk);
    push <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side. Pop is set at the falling edge; a word is taken at the
  // rising edge where pop is high and empty is low. Once, early in the run,
  // the receiver holds off for a long stretch while the sender keeps
  // offering bytes, so both queues fill and full must hold the input back.
  // --------------------------------------------------------------------------
  task automatic drain_words();
    int gap;
    int hold;
    bit held;
    gap  = 0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && bytes_sent >= HOLD_AFTER) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (gap > 0 && !calm) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        tracker.check_word(out_item);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 12);
      end
    end
  endtask

  // Ends the run when neither side has moved a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("id3v2_text_frame_extractor_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    in_item      = '0;
    stall_cycles = 0;
    bytes_sent   = 0;
    live_bytes   = 0;
    gap_odds     = 0;
    calm         = 1'b0;
    tracker      = new();

    // Directed opening: bytes before any tag, a bad magic on each of the
    // three magic positions, a tag whose size leaves no room for a frame,
    // and a byte after that tag has finished.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h49, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h49, 1'b1);
    queue_byte(8'h44, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h49, 1'b1);
    queue_byte(8'h44, 1'b0);
    queue_byte(8'h33, 1'b0);
    queue_byte(8'h04, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h0A, 1'b0);
    queue_byte(8'h55, 1'b0);

    // Random part: whole tags with random content and occasional damage.
    while (live_bytes < RANDOM_BYTES) add_tag();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    fork
      drain_words();
    join_none
    drive_bytes();

    // Wait for every predicted word, then give the pipeline time to show
    // any word that should not be there.
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("id3v2_text_frame_extractor_core_tb: clean");
    end else begin
      $display("id3v2_text_frame_extractor_core_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
